/* hw/rtl/iret_pkg.sv */
// package for the interval region edit table
// holds payload structs, action codes, controller states and command/status structs
// no dependencies
`default_nettype none
package iret_pkg;

   localparam int TableDepth = 64;
   localparam int AddrWidth  = 6;
   localparam int CountWidth = 7;
   localparam int EntryWidth = 44;

   typedef enum logic [2:0] {
      ACT_BEGIN  = 3'd0,
      ACT_LOAD   = 3'd1,
      ACT_ADD    = 3'd2,
      ACT_REMOVE = 3'd3,
      ACT_MODIFY = 3'd4,
      ACT_FINISH = 3'd5,
      ACT_RSVD6  = 3'd6,
      ACT_RSVD7  = 3'd7
   } action_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [23:0] field_number;
      logic [9:0]  line_number;
      logic [15:0] span_start;
      logic [15:0] span_end;
      logic [1:0]  basis_code;
   } req_type;

   typedef struct packed {
      logic [9:0]  out_line;
      logic [15:0] out_start;
      logic [15:0] out_end;
      logic [1:0]  out_basis;
      logic        out_valid;
      logic        out_last;
      logic        table_overflow;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  line;
      logic [15:0] start;
      logic [15:0] stop;
      logic [1:0]  basis;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDIT_RD,
      ST_EDIT_WAIT,
      ST_EDIT_STEP,
      ST_SORT_RD,
      ST_SORT_WAIT,
      ST_SORT_STEP,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;      // latch the accepted item
      logic do_begin;
      logic do_append;     // write item at count (load or add)
      logic use_user;      // basis from csr
      logic scan_clear;    // reset scan index and write index
      logic scan_read;     // issue ram read at scan index
      logic edit_step;     // process read entry for remove/modify
      logic edit_done;     // commit new count after remove
      logic sort_clear;    // reset min search over all entries
      logic sort_step;     // compare read entry against current best
      logic emit_load;     // load output register from read entry
      logic emit_empty;    // load empty result
      logic rsp_take;      // output transfer done
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       field_match;
      logic       table_full;
      logic       table_empty;
      logic       scan_last;   // scan index at count-1
      logic       emit_last;   // emitted count reached count
      logic       rsp_busy;
      logic [2:0] action;
   } sts_type;

endpackage
`default_nettype wire

/* hw/rtl/interval_region_edit_table.sv */
// interval region edit table.
// req channel: one item per transfer (begin, load, add, remove, modify, finish).
// rsp channel: on finish, one result per region in (line, start) order, ties in
//   table order; an empty table gives a single result with out_valid low.
// csr: write enable and data for the user basis code, taken at once.
// begin/load/add are done at decode; remove and modify scan all N regions,
//   one ram read per entry through the single read port.
// finish picks each emitted region by a selection pass over all N entries
//   through the same read port.
// only one item is in work at a time; a finished result sits in the output
//   register while the next item is taken, and a stalled receiver holds the
//   emit sequence until the result is transferred.
// reset (synchronous, active high) clears count, field, overflow and basis code;
//   table contents are left as is and never read before written.
// depends on iret_pkg, iret_ctrl, iret_dp, iret_ram
`default_nettype none
module interval_region_edit_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire iret_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output iret_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_wdata
);
   iret_pkg::cmd_type cmd;
   iret_pkg::sts_type sts;

   iret_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   iret_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

/* hw/rtl/iret_ram.sv */
// generic single-port-write, one-read ram with registered read
// no dependencies
`default_nettype none
module iret_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/iret_ctrl.sv */
// controller state machine for the interval region edit table
// depends on iret_pkg
`default_nettype none
module iret_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   input  wire iret_pkg::sts_type sts,
   output iret_pkg::cmd_type      cmd
);
   iret_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iret_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      cmd.rsp_take = sts.rsp_busy && rsp_ready;
      unique case (state_ff)
         iret_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take_req = req_valid;
         end
         iret_pkg::ST_EDIT_RD: begin
            // latched item decoded here
            unique case (iret_pkg::action_type'(sts.action)) inside
               iret_pkg::ACT_BEGIN: begin
                  cmd.do_begin = 1'b1;
                  state_in = iret_pkg::ST_IDLE;
               end
               iret_pkg::ACT_LOAD, iret_pkg::ACT_ADD: begin
                  if (sts.action == iret_pkg::ACT_LOAD || sts.field_match) begin
                     cmd.do_append = 1'b1;
                     cmd.use_user  = (sts.action == iret_pkg::ACT_ADD);
                  end
                  state_in = iret_pkg::ST_IDLE;
               end
               iret_pkg::ACT_REMOVE, iret_pkg::ACT_MODIFY: begin
                  if (sts.field_match && !sts.table_empty) begin
                     cmd.scan_clear = 1'b1;
                     state_in = iret_pkg::ST_EDIT_WAIT;
                  end else begin
                     state_in = iret_pkg::ST_IDLE;
                  end
               end
               iret_pkg::ACT_FINISH: begin
                  if (sts.rsp_busy) begin
                     state_in = iret_pkg::ST_EDIT_RD;
                  end else if (sts.table_empty) begin
                     cmd.emit_empty = 1'b1;
                     state_in = iret_pkg::ST_IDLE;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     cmd.sort_clear = 1'b1;
                     state_in = iret_pkg::ST_SORT_RD;
                  end
               end
               default: state_in = iret_pkg::ST_IDLE;
            endcase
         end
         iret_pkg::ST_EDIT_WAIT: begin
            cmd.scan_read = 1'b1;
            state_in = iret_pkg::ST_EDIT_STEP;
         end
         iret_pkg::ST_EDIT_STEP: begin
            cmd.edit_step = 1'b1;
            if (sts.scan_last) begin
               cmd.edit_done = 1'b1;
               state_in = iret_pkg::ST_IDLE;
            end else begin
               state_in = iret_pkg::ST_EDIT_WAIT;
            end
         end
         iret_pkg::ST_SORT_RD: begin
            cmd.scan_read = 1'b1;
            state_in = iret_pkg::ST_SORT_STEP;
         end
         iret_pkg::ST_SORT_STEP: begin
            cmd.sort_step = 1'b1;
            state_in = sts.scan_last ? iret_pkg::ST_EMIT_RD : iret_pkg::ST_SORT_RD;
         end
         iret_pkg::ST_EMIT_RD: begin
            state_in = iret_pkg::ST_EMIT_WAIT;
         end
         iret_pkg::ST_EMIT_WAIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit_load = 1'b1;
               state_in = iret_pkg::ST_EMIT_OUT;
            end
         end
         iret_pkg::ST_EMIT_OUT: begin
            if (sts.emit_last) begin
               state_in = iret_pkg::ST_IDLE;
            end else begin
               cmd.scan_clear = 1'b1;
               cmd.sort_clear = 1'b1;
               state_in = iret_pkg::ST_SORT_RD;
            end
         end
         default: state_in = iret_pkg::ST_IDLE;
      endcase
      if (state_ff == iret_pkg::ST_IDLE && req_valid) begin
         state_in = iret_pkg::ST_EDIT_RD;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/iret_dp.sv */
// datapath: region ram, latched item, scan/sort registers, output register
// depends on iret_pkg and iret_ram
`default_nettype none
module iret_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire iret_pkg::req_type req_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_wdata,
   input  wire iret_pkg::cmd_type cmd,
   output iret_pkg::sts_type      sts,
   output logic                   rsp_valid,
   output iret_pkg::rsp_type      rsp_data
);
   localparam int AW = iret_pkg::AddrWidth;
   localparam int CW = iret_pkg::CountWidth;

   iret_pkg::req_type   item_ff;
   logic [1:0]          user_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [23:0]         field_ff;
   logic                ovf_ff;
   logic [AW-1:0]       scan_ff, wr_idx_ff;
   logic [CW-1:0]       emitted_ff;
   // last emitted key and index; next pick is smallest (key,idx) above it
   logic [25:0]         prev_key_ff;
   logic [AW-1:0]       prev_idx_ff;
   logic                have_prev_ff;
   logic [25:0]         best_key_ff;
   logic [AW-1:0]       best_idx_ff;
   logic                have_best_ff;
   logic                rsp_valid_ff;
   iret_pkg::rsp_type   rsp_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   iret_pkg::entry_type wr_entry, rd_entry;
   logic [iret_pkg::EntryWidth-1:0] rd_raw;
   logic                ovl;
   logic [15:0]         lo, hi;
   logic [25:0]         key;
   logic                after_prev, before_best;

   iret_ram #(.Width(iret_pkg::EntryWidth), .Depth(iret_pkg::TableDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_entry = iret_pkg::entry_type'(rd_raw);

   // overlap test of read entry against latched item
   always_comb begin
      lo  = (rd_entry.start > item_ff.span_start) ? rd_entry.start : item_ff.span_start;
      hi  = (rd_entry.stop < item_ff.span_end) ? rd_entry.stop : item_ff.span_end;
      ovl = (rd_entry.line == item_ff.line_number) && (lo < hi);
      key = {rd_entry.line, rd_entry.start};
      after_prev  = !have_prev_ff || (key > prev_key_ff) ||
                    ((key == prev_key_ff) && (scan_ff > prev_idx_ff));
      before_best = !have_best_ff || (key < best_key_ff);
   end

   // ram port muxing
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_entry = '{line: item_ff.line_number, start: item_ff.span_start,
                   stop: item_ff.span_end,
                   basis: cmd.use_user ? user_ff : item_ff.basis_code};
      rd_addr  = scan_ff;
      if (cmd.do_append && !sts.table_full) begin
         wr_en = 1'b1;
      end else if (cmd.edit_step) begin
         if (item_ff.action == iret_pkg::ACT_REMOVE) begin
            wr_en    = !ovl;
            wr_addr  = wr_idx_ff;
            wr_entry = rd_entry;
         end else begin
            wr_en    = ovl;
            wr_addr  = scan_ff;
            wr_entry = '{line: rd_entry.line, start: item_ff.span_start,
                         stop: item_ff.span_end, basis: rd_entry.basis};
         end
      end
      if (cmd.emit_load || !cmd.scan_read && !cmd.sort_step && !cmd.edit_step) begin
         rd_addr = best_idx_ff;
      end
   end

   // status
   always_comb begin
      sts.field_match = (item_ff.field_number == field_ff);
      sts.table_full  = (count_ff == CW'(iret_pkg::TableDepth));
      sts.table_empty = (count_ff == '0);
      sts.scan_last   = ({1'b0, scan_ff} == count_ff - CW'(1));
      sts.emit_last   = (emitted_ff == count_ff);
      sts.rsp_busy    = rsp_valid_ff;
      sts.action      = item_ff.action;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_begin) begin
         count_in = '0;
      end else if (cmd.do_append && !sts.table_full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.edit_done && item_ff.action == iret_pkg::ACT_REMOVE) begin
         count_in = {1'b0, wr_idx_ff} + CW'(!ovl);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         field_ff     <= '0;
         ovf_ff       <= 1'b0;
         user_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         emitted_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            user_ff <= csr_wdata;
         end
         if (cmd.do_begin) begin
            field_ff <= item_ff.field_number;
            ovf_ff   <= 1'b0;
         end else if (cmd.do_append && sts.table_full) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit_load || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end
         if (cmd.take_req) begin
            have_prev_ff <= 1'b0;
            emitted_ff   <= '0;
         end else if (cmd.emit_load) begin
            have_prev_ff <= 1'b1;
            emitted_ff   <= emitted_ff + CW'(1);
         end
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         item_ff <= req_data;
      end
      if (cmd.scan_clear) begin
         scan_ff   <= '0;
         wr_idx_ff <= '0;
      end else if (cmd.edit_step || cmd.sort_step) begin
         scan_ff <= scan_ff + AW'(1);
         if (cmd.edit_step && !ovl) begin
            wr_idx_ff <= wr_idx_ff + AW'(1);
         end
      end
      if (cmd.sort_clear) begin
         have_best_ff <= 1'b0;
      end else if (cmd.sort_step && after_prev && before_best) begin
         have_best_ff <= 1'b1;
         best_key_ff  <= key;
         best_idx_ff  <= scan_ff;
      end
      if (cmd.emit_load) begin
         prev_key_ff <= best_key_ff;
         prev_idx_ff <= best_idx_ff;
         rsp_ff <= '{out_line: rd_entry.line, out_start: rd_entry.start,
                     out_end: rd_entry.stop, out_basis: rd_entry.basis,
                     out_valid: 1'b1, out_last: (emitted_ff + CW'(1) == count_ff),
                     table_overflow: ovf_ff};
      end else if (cmd.emit_empty) begin
         rsp_ff <= '{out_line: '0, out_start: '0, out_end: '0, out_basis: '0,
                     out_valid: 1'b0, out_last: 1'b1,
                     table_overflow: ovf_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
